@@ rtl/core/tdp_pkg.sv @@
// Shared constants and controller/datapath interface types for the prime tester.
package tdp_pkg;

	// Default width of the candidate number.
	localparam int unsigned VALUE_BITS_DEFAULT = 16;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture a new candidate, set divisor to two
		logic rem_start;  // clear the remainder and begin a long division
		logic rem_step;   // one restoring division step
		logic next_div;   // advance the divisor and its square
		logic emit;       // write the result register
		logic flag;       // prime flag to write with emit
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic below_two;  // candidate is zero or one
		logic sq_over;    // divisor squared exceeds the candidate
		logic rem_last;   // the current division step is the last one
		logic rem_zero;   // the finished remainder is zero
	} status_t;

endpackage

@@ rtl/core/tdp_datapath.sv @@
// Datapath: operand and divisor registers, bit-serial remainder unit and result register.
module tdp_datapath #(
	parameter int unsigned VALUE_BITS = tdp_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tdp_pkg::cmd_t         cmd,
	output tdp_pkg::status_t      status,
	input  logic [VALUE_BITS-1:0] candidate,
	output logic [VALUE_BITS-1:0] tested_value,
	output logic                  prime_flag
);

	localparam int unsigned CNT_BITS = (VALUE_BITS > 2) ? $clog2(VALUE_BITS) : 1;
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);

	logic [VALUE_BITS-1:0] value_q;
	logic [VALUE_BITS-1:0] div_q;
	logic [VALUE_BITS:0]   sq_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] shift_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [VALUE_BITS-1:0] tested_value_q;
	logic                  prime_flag_q;

	logic [VALUE_BITS:0]   partial;
	logic [VALUE_BITS:0]   diff;
	logic [VALUE_BITS-1:0] rem_next;

	// One restoring division step: bring down the next candidate bit and subtract if it fits.
	assign partial  = {rem_q, shift_q[VALUE_BITS-1]};
	assign diff     = partial - {1'b0, div_q};
	assign rem_next = diff[VALUE_BITS] ? partial[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];

	// Status toward the controller.
	assign status.below_two = (value_q[VALUE_BITS-1:1] == '0);
	assign status.sq_over   = (sq_q > {1'b0, value_q});
	assign status.rem_last  = (cnt_q == '0);
	assign status.rem_zero  = (rem_q == '0);

	// Operand, divisor, remainder and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q        <= '0;
			div_q          <= '0;
			sq_q           <= '0;
			rem_q          <= '0;
			shift_q        <= '0;
			cnt_q          <= '0;
			tested_value_q <= '0;
			prime_flag_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				value_q <= candidate;
				div_q   <= VALUE_BITS'(2);
				sq_q    <= (VALUE_BITS + 1)'(4);
			end else if (cmd.next_div) begin
				div_q <= div_q + VALUE_BITS'(1);
				sq_q  <= sq_q + {div_q, 1'b1};
			end
			if (cmd.rem_start) begin
				rem_q   <= '0;
				shift_q <= value_q;
				cnt_q   <= CNT_LAST;
			end else if (cmd.rem_step) begin
				rem_q   <= rem_next;
				shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
				cnt_q   <= cnt_q - CNT_BITS'(1);
			end
			if (cmd.emit) begin
				tested_value_q <= value_q;
				prime_flag_q   <= cmd.flag;
			end
		end
	end

	assign tested_value = tested_value_q;
	assign prime_flag   = prime_flag_q;

endmodule

@@ rtl/core/tdp_controller.sv @@
// Controller: sequences the divisor scan and owns both handshakes.
module tdp_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  tdp_pkg::status_t  status,
	output tdp_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_TEST,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   flag_q;
	logic   out_free;

	// The result register can take a new result when empty or being drained.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Commands decoded from the current state and status.
	always_comb begin
		cmd           = '0;
		cmd.flag      = flag_q;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.rem_start = (state_q == ST_CHECK) && !status.below_two && !status.sq_over;
		cmd.rem_step  = (state_q == ST_DIVIDE);
		cmd.next_div  = (state_q == ST_TEST) && !status.rem_zero;
		cmd.emit      = (state_q == ST_EMIT) && out_free;
	end

	// State, result flag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			flag_q      <= 1'b0;
		end else begin
			// Output valid rises with a new result and falls once the result is taken.
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (status.below_two) begin
						flag_q  <= 1'b0;
						state_q <= ST_EMIT;
					end else if (status.sq_over) begin
						flag_q  <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					if (status.rem_last) begin
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if (status.rem_zero) begin
						flag_q  <= 1'b0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/trial_division_prime_test.sv @@
// Top level of the trial-division prime tester: controller plus datapath.
//
// Each request carries one unsigned candidate and yields one result: the candidate
// echoed and a flag that is 1 when it is prime. Zero and one are not prime. Trial
// divisors run from two upward and the scan stops at the first divisor that divides
// the candidate evenly or once the divisor squared exceeds the candidate. Every
// divisor is tried in the single bit-serial remainder unit, one restoring step per
// cycle, with a check state before and a test state after, so the time that an item
// takes grows with the number of divisors tried; a 16-bit prime near 65521 tries
// 254 divisors. One item is in work at a time; the result register lets the next
// request be accepted while the previous result waits to be taken.
module trial_division_prime_test #(
	parameter int unsigned VALUE_BITS = tdp_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_BITS-1:0] candidate,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [VALUE_BITS-1:0] tested_value,
	output logic                  prime_flag
);

	tdp_pkg::cmd_t    cmd;
	tdp_pkg::status_t status;

	// Sequencer for the divisor scan and the handshakes.
	tdp_controller u_controller (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Operand registers, remainder unit and result register.
	tdp_datapath #(
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.candidate    (candidate),
		.tested_value (tested_value),
		.prime_flag   (prime_flag)
	);

endmodule
